[rtl/skt_pkg.sv]
package skt_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 32;
	localparam int POS_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_FIND   = 3'd1,
		OP_REMOVE = 3'd2,
		OP_COUNT  = 3'd3,
		OP_FWD    = 3'd4,
		OP_BACK   = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_REWIND = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DUP     = 3'd1,
		ST_MISSING = 3'd2,
		ST_FULL    = 3'd3,
		ST_END     = 3'd4
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture request word
		logic commit;  // apply the search result and update the table
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy_res; // result register holds an undelivered word
	} sts_t;

endpackage

[rtl/sorted_key_table.sv]
// sorted_key_table: holds up to 16 distinct signed 32-bit keys in ascending order
// in a row of comparing cells that shift in parallel. Each request word
// (opcode, key) gives exactly one result word. All cells compare the key in
// the accept cycle, then the rank is summed and the table shifts and the
// result is registered. The next word is taken the cycle after that result
// has been taken, so no new word is taken while a request is in work or its
// result waits; an item is accepted on valid high, stall low.
module sorted_key_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] key,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] key_out,
	output logic [3:0]         rank,
	output logic [4:0]         entry_count
);

	skt_pkg::cmd_t cmd;
	skt_pkg::sts_t sts;

	// sequencing of each request
	skt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	// key cells, cursor and result register
	skt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.opcode(opcode), .key(key),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .key_out(key_out), .rank(rank), .entry_count(entry_count)
	);

endmodule

[rtl/skt_ctrl.sv]
module skt_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  skt_pkg::sts_t sts,
	output skt_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_SEARCH = 2'b10
	} state_t;

	state_t state_q;

	// take a new word while idle unless a result still waits
	assign in_stall   = (state_q != S_IDLE) || sts.busy_res;
	assign cmd.load   = in_valid && !in_stall;
	assign cmd.commit = (state_q == S_SEARCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (cmd.load) state_q <= S_SEARCH;
				S_SEARCH: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	a_commit_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.commit) else $error("commit did not follow load");
	a_no_load_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !cmd.load) else $error("load during search");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");

endmodule

[rtl/skt_dp.sv]
module skt_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skt_pkg::cmd_t         cmd,
	output skt_pkg::sts_t         sts,
	input  logic [2:0]            opcode,
	input  logic signed [31:0]    key,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic signed [31:0]    key_out,
	output logic [3:0]            rank,
	output logic [4:0]            entry_count
);

	localparam int CAP = skt_pkg::CAPACITY;
	localparam int PB  = skt_pkg::POS_BITS;
	localparam int CB  = skt_pkg::CNT_BITS;

	skt_pkg::key_t key_q [CAP];
	skt_pkg::cnt_t occ_q;
	skt_pkg::pos_t cur_pos_q;
	logic          cur_vld_q;

	skt_pkg::op_t  op_s1;
	skt_pkg::key_t key_s1;
	logic [CAP-1:0] lt_s1;  // per cell: key held is below request
	logic [CAP-1:0] eq_s1;  // per cell: key held equals request

	logic res_vld_q;

	// cell compares on the incoming word, registered for the commit cycle
	skt_pkg::key_t kin;
	assign kin = skt_pkg::key_t'($signed(key));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1  <= skt_pkg::op_t'(opcode);
			key_s1 <= kin;
			for (int i = 0; i < CAP; i++) begin
				lt_s1[i] <= (CB'(i) < occ_q) && (key_q[i] < kin);
				eq_s1[i] <= (CB'(i) < occ_q) && (key_q[i] == kin);
			end
		end
	end

	// lower position: number of held keys below the request
	skt_pkg::cnt_t p_c;
	logic          hit_c;
	always_comb begin
		p_c   = '0;
		hit_c = |eq_s1;
		for (int i = 0; i < CAP; i++) p_c = p_c + CB'(lt_s1[i]);
	end
	skt_pkg::pos_t p_pos;
	assign p_pos = p_c[PB-1:0];

	// cursor step logic
	logic          step_ok_c;
	skt_pkg::pos_t step_pos_c;
	always_comb begin
		step_ok_c  = 1'b0;
		step_pos_c = '0;
		if (!cur_vld_q) begin
			step_ok_c  = (occ_q != '0);
			step_pos_c = (op_s1 == skt_pkg::OP_FWD) ? '0 : PB'(occ_q - CB'(1));
		end else if (op_s1 == skt_pkg::OP_FWD) begin
			step_ok_c  = (CB'(cur_pos_q) + CB'(1)) < occ_q;
			step_pos_c = cur_pos_q + PB'(1);
		end else begin
			step_ok_c  = (cur_pos_q != '0);
			step_pos_c = cur_pos_q - PB'(1);
		end
	end

	logic full_c;
	assign full_c = (occ_q >= CB'(CAP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			cur_pos_q <= '0;
			cur_vld_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) res_vld_q <= 1'b0;
			if (cmd.commit) begin
				res_vld_q <= 1'b1;
				case (op_s1)
					skt_pkg::OP_INSERT: if (!hit_c && !full_c) begin
						occ_q <= occ_q + CB'(1);
						if (cur_vld_q && p_pos <= cur_pos_q) cur_pos_q <= cur_pos_q + PB'(1);
					end
					skt_pkg::OP_REMOVE: if (hit_c) begin
						occ_q <= occ_q - CB'(1);
						if (cur_vld_q) begin
							if (cur_pos_q == p_pos) begin
								cur_vld_q <= 1'b0;
								cur_pos_q <= '0;
							end else if (p_pos < cur_pos_q) begin
								cur_pos_q <= cur_pos_q - PB'(1);
							end
						end
					end
					skt_pkg::OP_FWD, skt_pkg::OP_BACK: begin
						cur_vld_q <= step_ok_c;
						cur_pos_q <= step_ok_c ? step_pos_c : '0;
					end
					skt_pkg::OP_CLEAR: begin
						occ_q     <= '0;
						cur_vld_q <= 1'b0;
						cur_pos_q <= '0;
					end
					skt_pkg::OP_REWIND: begin
						cur_vld_q <= 1'b0;
						cur_pos_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// key cells shift in parallel
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (op_s1 == skt_pkg::OP_INSERT && !hit_c && !full_c) begin
				for (int i = 0; i < CAP; i++) begin
					if (PB'(i) == p_pos) key_q[i] <= key_s1;
					else if (i > 0 && PB'(i) > p_pos) key_q[i] <= key_q[(i > 0) ? i-1 : 0];
				end
			end else if (op_s1 == skt_pkg::OP_REMOVE && hit_c) begin
				for (int i = 0; i < CAP-1; i++)
					if (PB'(i) >= p_pos) key_q[i] <= key_q[i+1];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status  <= skt_pkg::ST_OK;
			key_out <= '0;
			rank    <= '0;
			case (op_s1)
				skt_pkg::OP_INSERT: begin
					if (hit_c) begin
						status  <= skt_pkg::ST_DUP;
						key_out <= 32'(key_s1);
						rank    <= 4'(p_pos);
					end else if (full_c) begin
						status <= skt_pkg::ST_FULL;
					end else begin
						key_out <= 32'(key_s1);
						rank    <= 4'(p_pos);
					end
				end
				skt_pkg::OP_FIND, skt_pkg::OP_REMOVE: begin
					if (hit_c) begin
						key_out <= 32'(key_s1);
						rank    <= 4'(p_pos);
					end else begin
						status <= skt_pkg::ST_MISSING;
					end
				end
				skt_pkg::OP_FWD, skt_pkg::OP_BACK: begin
					if (step_ok_c) begin
						key_out <= 32'(key_q[step_pos_c]);
						rank    <= 4'(step_pos_c);
					end else begin
						status <= skt_pkg::ST_END;
					end
				end
				default: ;
			endcase
		end
	end

	assign entry_count  = 5'(occ_q);
	assign out_valid    = res_vld_q;
	assign sts.busy_res = res_vld_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CB'(CAP)) else $error("occupancy above capacity");
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> (CB'(cur_pos_q) < occ_q)) else $error("cursor past table");
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $onehot0(eq_s1)) else $error("duplicate keys stored");

endmodule
